// File: sv/kacl_pkg.sv
// Shared constants and types for the key afterglow LED colourer.
// Holds register defaults, register indexes, request codes and the divider interface.
// No dependencies.
`default_nettype none

package kacl_pkg;

	localparam int LED_COUNT_DEF = 47;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_GLOW_TOTAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLOW_FULL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_STEP = 2'd2;

	localparam logic [CFG_W-1:0] GLOW_TOTAL_RST = 16'd1000;
	localparam logic [CFG_W-1:0] GLOW_FULL_RST  = 16'd500;
	localparam logic [CFG_W-1:0] COLOR_STEP_RST = 16'd100;

	localparam logic [1:0] MODE_RELEASE = 2'd0;
	localparam logic [1:0] MODE_FRAME   = 2'd1;
	localparam logic [1:0] MODE_RENDER  = 2'd2;

	// fade divider: numerator is the 16-bit fade offset times 128
	localparam int DIV_NUM_W = 23;
	localparam int DIV_DEN_W = 16;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: sv/kacl_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module kacl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 47
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: sv/kacl_div.sv
// Serial restoring divider for the afterglow fade, one quotient bit per cycle.
// Depends on kacl_pkg for the request and response structs.
`default_nettype none

module kacl_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kacl_pkg::div_req_t req,
	output kacl_pkg::div_rsp_t      rsp
);

	localparam int NW  = kacl_pkg::DIV_NUM_W;
	localparam int DW  = kacl_pkg::DIV_DEN_W;
	localparam int CW  = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [DW-1:0] den_q;
	logic [DW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [DW:0]   trial;
	logic          ge;
	logic [DW:0]   diff;

	assign trial = {rem_q, num_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			// shift the quotient bit in where the numerator bit left
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = num_q;

endmodule

`default_nettype wire

// File: sv/key_afterglow_led_colorizer.sv
// Key afterglow LED colourer: how to use it.
// Input channel (in_valid / in_stall) carries one request: mode, led_num, layer,
// now_ms. A key release stamps that LED's glow start and is done in the cycle it is
// taken. A frame start tests whether the 31-bit hue seed is due to advance, advances
// it in ST_SEED_ADD if so, then sweeps every LED's glow start, one LED a cycle,
// retiring expired glows. A render returns one colour on the output channel
// (out_valid / out_stall): led_out, red, green, blue. It keeps the input stalled
// through its check and colour steps, and the colour is registered; a render that
// finds a fading glow runs the serial fade divider, one quotient bit a cycle, in a
// divide step between them. Requests that produce nothing (render off the board,
// unused mode) are done in the cycle they are taken.
// in_stall is high while a request is being worked on. The output register parts
// the two channels: a new request is taken while a colour still waits; a later
// colour holds in the final step until the waiting one is taken.
// The user writes configuration (cfg_wr_en, cfg_index, cfg_wdata) only while idle; the block does not enforce it.
// Reset: glows dead, seed one, last step time zero, registers at their defaults.
// The glow start store needs no clearing pass: a per-LED live bit guards it.
`default_nettype none

module key_afterglow_led_colorizer #(
	parameter int LED_COUNT = kacl_pkg::LED_COUNT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     mode,
	input  wire logic [7:0]                     led_num,
	input  wire logic [1:0]                     layer,
	input  wire logic [31:0]                    now_ms,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [7:0]                     led_out,
	output logic      [7:0]                     red,
	output logic      [7:0]                     green,
	output logic      [7:0]                     blue,
	input  wire logic                           cfg_wr_en,
	input  wire logic [kacl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kacl_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int IDX_W = LED_COUNT > 1 ? $clog2(LED_COUNT) : 1;
	localparam int CNT_W = $clog2(LED_COUNT + 1);

	localparam logic [30:0] SEED_MULT = 31'd1103515245;
	localparam logic [30:0] SEED_INC  = 31'd12345;
	localparam logic [31:0] HUE_MULT  = 32'd2654435761;

	localparam logic [1:0] LYR_HUE   = 2'd0;
	localparam logic [1:0] LYR_HOME  = 2'd1;
	localparam logic [1:0] LYR_NAV   = 2'd2;
	localparam logic [1:0] LYR_SOLID = 2'd3;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_ADD,
		ST_SWEEP,
		ST_REN_CHK,
		ST_DIV,
		ST_COLOR
	} state_t;

	function automatic rgb_t base_rgb(logic [31:0] k, logic [7:0] idx, logic [1:0] lyr);
		rgb_t       c;
		logic [7:0] x;
		logic [7:0] m120;
		logic [7:0] m80;
		logic [7:0] m160;
		c = '0;
		x = k[7:0];
		m120 = x >= 8'd240 ? x - 8'd240 : (x >= 8'd120 ? x - 8'd120 : x);
		x = k[15:8];
		m80 = x >= 8'd240 ? x - 8'd240 :
			(x >= 8'd160 ? x - 8'd160 : (x >= 8'd80 ? x - 8'd80 : x));
		x = k[23:16];
		m160 = x >= 8'd160 ? x - 8'd160 : x;
		case (lyr)
			LYR_HUE: begin
				c.r = (8'd161 - m120) >> 1;
				c.g = m80 >> 1;
				c.b = (8'd246 - m160) >> 1;
			end
			LYR_HOME: begin
				if ((idx >= 8'd1 && idx <= 8'd10) || (idx >= 8'd13 && idx <= 8'd22)) begin
					c.r = 8'd255;
					c.g = 8'd255;
				end
			end
			LYR_NAV: begin
				if (idx == 8'd0 || idx == 8'd11 || (idx >= 8'd18 && idx <= 8'd21) ||
				    idx == 8'd27 || idx == 8'd37 || idx == 8'd42 || idx == 8'd43) begin
					c.g = 8'd255;
				end
			end
			LYR_SOLID: begin
				c.r = 8'd255;
			end
			default: begin
				c = '0;
			end
		endcase
		return c;
	endfunction

	state_t                      state_q;
	logic [kacl_pkg::CFG_W-1:0]  total_q;
	logic [kacl_pkg::CFG_W-1:0]  full_q;
	logic [kacl_pkg::CFG_W-1:0]  step_q;
	logic [LED_COUNT-1:0]        live_q;
	logic [30:0]                 seed_q;
	logic [31:0]                 last_q;
	logic [30:0]                 prod_s1;
	logic [31:0]                 kmul_s1;
	logic [7:0]                  led_q;
	logic [1:0]                  layer_q;
	logic [31:0]                 now_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        chk_vld_s1;
	logic [IDX_W-1:0]            chk_idx_s1;
	logic                        white_use_q;
	logic [7:0]                  white_q;
	logic                        out_valid_q;
	logic [7:0]                  led_out_q;
	rgb_t                        rgb_q;

	logic                        in_acc;
	logic                        in_on_board;
	logic                        rel_wr;
	logic [IDX_W-1:0]            ram_raddr;
	logic [31:0]                 ram_rdata;
	logic [31:0]                 elapsed;
	logic [31:0]                 sweep_elapsed;
	logic                        ren_live;
	logic                        ren_expired;
	logic                        ren_fading;
	logic [kacl_pkg::CFG_W-1:0]  fade_off;
	logic                        sweep_issue;
	logic                        out_busy;
	logic                        out_load;
	rgb_t                        base_c;
	kacl_pkg::div_req_t          div_req;
	kacl_pkg::div_rsp_t          div_rsp;

	assign in_stall    = state_q != ST_IDLE;
	assign in_acc      = in_valid && !in_stall;
	assign in_on_board = led_num < 8'(LED_COUNT);
	assign rel_wr      = in_acc && mode == kacl_pkg::MODE_RELEASE && in_on_board;
	assign sweep_issue = state_q == ST_SWEEP && cnt_q < CNT_W'(LED_COUNT);
	assign ram_raddr   = state_q == ST_SWEEP ? cnt_q[IDX_W-1:0] : led_num[IDX_W-1:0];

	kacl_ram #(
		.WIDTH(32),
		.DEPTH(LED_COUNT)
	) u_start_ram (
		.clk  (clk),
		.we   (rel_wr),
		.waddr(led_num[IDX_W-1:0]),
		.wdata(now_ms),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// render decision, read data is the glow start of led_q
	assign elapsed     = now_q - ram_rdata;
	assign ren_live    = live_q[led_q[IDX_W-1:0]];
	assign ren_expired = elapsed >= {16'd0, total_q};
	assign ren_fading  = elapsed >= {16'd0, full_q};
	assign fade_off    = elapsed[kacl_pkg::CFG_W-1:0] - full_q;

	assign div_req.start = state_q == ST_REN_CHK && ren_live && !ren_expired && ren_fading;
	assign div_req.num   = {fade_off, 7'd0};
	assign div_req.den   = total_q - full_q;

	kacl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign sweep_elapsed = now_q - ram_rdata;
	assign base_c        = base_rgb(32'(seed_q) + kmul_s1, led_q, layer_q);
	assign out_busy      = out_valid_q && out_stall;
	assign out_load      = state_q == ST_COLOR && !out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= kacl_pkg::GLOW_TOTAL_RST;
			full_q  <= kacl_pkg::GLOW_FULL_RST;
			step_q  <= kacl_pkg::COLOR_STEP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				kacl_pkg::REG_GLOW_TOTAL: total_q <= cfg_wdata;
				kacl_pkg::REG_GLOW_FULL:  full_q  <= cfg_wdata;
				kacl_pkg::REG_COLOR_STEP: step_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			live_q      <= '0;
			seed_q      <= 31'd1;
			last_q      <= '0;
			prod_s1     <= '0;
			kmul_s1     <= '0;
			led_q       <= '0;
			layer_q     <= '0;
			now_q       <= '0;
			cnt_q       <= '0;
			chk_vld_s1  <= 1'b0;
			chk_idx_s1  <= '0;
			white_use_q <= 1'b0;
			white_q     <= '0;
			out_valid_q <= 1'b0;
			led_out_q   <= '0;
			rgb_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						led_q   <= led_num;
						layer_q <= layer;
						now_q   <= now_ms;
						case (mode)
							kacl_pkg::MODE_RELEASE: begin
								if (in_on_board) begin
									live_q[led_num[IDX_W-1:0]] <= 1'b1;
								end
							end
							kacl_pkg::MODE_FRAME: begin
								state_q <= ST_SEED_MUL;
							end
							kacl_pkg::MODE_RENDER: begin
								if (in_on_board) begin
									state_q <= ST_REN_CHK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SEED_MUL: begin
					cnt_q <= '0;
					if (layer_q == LYR_HUE && (now_q - last_q) > {16'd0, step_q}) begin
						prod_s1 <= seed_q * SEED_MULT;
						last_q  <= now_q;
						state_q <= ST_SEED_ADD;
					end else begin
						state_q <= ST_SWEEP;
					end
				end
				ST_SEED_ADD: begin
					seed_q  <= prod_s1 + SEED_INC;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					// read one glow start a cycle, check it the cycle after
					if (chk_vld_s1 && live_q[chk_idx_s1] &&
					    sweep_elapsed >= {16'd0, total_q}) begin
						live_q[chk_idx_s1] <= 1'b0;
					end
					chk_vld_s1 <= sweep_issue;
					chk_idx_s1 <= cnt_q[IDX_W-1:0];
					if (sweep_issue) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_REN_CHK: begin
					kmul_s1 <= 32'(led_q) * HUE_MULT;
					white_q <= 8'd255;
					if (!ren_live) begin
						white_use_q <= 1'b0;
						state_q     <= ST_COLOR;
					end else if (ren_expired) begin
						live_q[led_q[IDX_W-1:0]] <= 1'b0;
						white_use_q <= 1'b0;
						state_q     <= ST_COLOR;
					end else if (!ren_fading) begin
						white_use_q <= 1'b1;
						state_q     <= ST_COLOR;
					end else begin
						white_use_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						white_q <= 8'd255 - div_rsp.quo[7:0];
						state_q <= ST_COLOR;
					end
				end
				ST_COLOR: begin
					// hold until the waiting colour is taken
					if (out_load) begin
						led_out_q   <= led_q;
						rgb_q       <= white_use_q ? rgb_t'{white_q, white_q, white_q} : base_c;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign led_out   = led_out_q;
	assign red       = rgb_q.r;
	assign green     = rgb_q.g;
	assign blue      = rgb_q.b;

`ifndef SYNTHESIS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("fade divider finished outside the divide step");

	a_out_from_color: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_COLOR))
		else $error("colour presented without a colour step");

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP && !sweep_issue |=> state_q == ST_IDLE)
		else $error("glow sweep did not return to idle");

	a_render_enters_chk: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && mode == kacl_pkg::MODE_RENDER && in_on_board |=> state_q == ST_REN_CHK)
		else $error("render request not checked");
`endif

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for key_afterglow_led_colorizer: a queue-fed driver, a checking monitor,
// a local colour predictor and several register settings. Needs kacl_pkg and the RTL top.
`timescale 1ns / 1ps

module testbench;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	// let a frame sweep finish before a register write
	localparam int SETTLE_CYCLES = 100;
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  led;
		logic [1:0]  layer;
		logic [31:0] now;
	} led_req_t;

	typedef struct packed {
		logic [7:0] led;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} led_rgb_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_stall;
	logic [1:0]                     mode      = kacl_pkg::MODE_RELEASE;
	logic [7:0]                     led_num   = 8'd0;
	logic [1:0]                     layer     = 2'd0;
	logic [31:0]                    now_ms    = 32'd0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [7:0]                     led_out;
	logic [7:0]                     red;
	logic [7:0]                     green;
	logic [7:0]                     blue;
	logic                           cfg_wr_en = 1'b0;
	logic [kacl_pkg::CFG_IDX_W-1:0] cfg_index = kacl_pkg::REG_GLOW_TOTAL;
	logic [kacl_pkg::CFG_W-1:0]     cfg_wdata = '0;

	key_afterglow_led_colorizer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.led_num   (led_num),
		.layer     (layer),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.led_out   (led_out),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// colour predictor state
	logic              glow_on [kacl_pkg::LED_COUNT_DEF];
	logic [31:0]       glow_t0 [kacl_pkg::LED_COUNT_DEF];
	logic [30:0]       hue_seed_m;
	logic [31:0]       hue_stamp_m;
	int unsigned       total_ms_m;
	int unsigned       full_ms_m;
	int unsigned       step_ms_m;

	led_req_t          req_backlog[$];
	led_rgb_t          colours_due[$];

	led_req_t          drv_req;
	int                gap_left      = 0;
	bit                drv_burst     = 1'b0;
	int                stall_left    = 0;
	bit                mon_burst     = 1'b0;
	int                hold_left     = 0;
	bit                hold_used     = 1'b0;
	int                colours_seen  = 0;
	int                fail_cnt      = 0;
	int                quiet_cycles  = 0;
	int                n_release     = 0;
	int                n_frame       = 0;
	int                n_render      = 0;
	int                n_settings    = 1;
	int                queued_live   = 0;
	logic [31:0]       t_now         = 32'd0;

	function automatic led_rgb_t base_rgb(logic [7:0] led, logic [1:0] lyr);
		led_rgb_t    c;
		logic [31:0] k;
		int unsigned kr, kg, kb;
		c     = '0;
		c.led = led;
		case (lyr)
			2'd0: begin
				k     = {1'b0, hue_seed_m} + led * 32'd2654435761;
				kr    = k[7:0];
				kg    = k[15:8];
				kb    = k[23:16];
				c.r   = 8'((161 - kr % 120) / 2);
				c.g   = 8'((kg % 80) / 2);
				c.b   = 8'((246 - kb % 160) / 2);
			end
			2'd1: begin
				if ((led >= 1 && led <= 10) || (led >= 13 && led <= 22)) begin
					c.r = 8'd255;
					c.g = 8'd255;
				end
			end
			2'd2: begin
				if (led == 0 || led == 11 || (led >= 18 && led <= 21) || led == 27 ||
				    led == 37 || led == 42 || led == 43)
					c.g = 8'd255;
			end
			default: c.r = 8'd255;
		endcase
		return c;
	endfunction

	function automatic void predict_request(led_req_t q);
		led_rgb_t    c;
		logic [31:0] e;
		logic [63:0] nxt;
		int unsigned w;
		int          i;
		case (q.mode)
			kacl_pkg::MODE_RELEASE: begin
				if (q.led != 8'hff && q.led < kacl_pkg::LED_COUNT_DEF) begin
					glow_t0[q.led] = q.now;
					glow_on[q.led] = 1'b1;
				end
			end
			kacl_pkg::MODE_FRAME: begin
				e = q.now - hue_stamp_m;
				if (q.layer == 2'd0 && e > step_ms_m) begin
					nxt         = 64'(hue_seed_m) * 64'd1103515245 + 64'd12345;
					hue_seed_m  = nxt[30:0];
					hue_stamp_m = q.now;
				end
				for (i = 0; i < kacl_pkg::LED_COUNT_DEF; i++) begin
					e = q.now - glow_t0[i];
					if (glow_on[i] && e >= total_ms_m)
						glow_on[i] = 1'b0;
				end
			end
			kacl_pkg::MODE_RENDER: begin
				if (q.led < kacl_pkg::LED_COUNT_DEF) begin
					c = base_rgb(q.led, q.layer);
					if (glow_on[q.led]) begin
						e = q.now - glow_t0[q.led];
						if (e >= total_ms_m) begin
							glow_on[q.led] = 1'b0;
						end else begin
							w = 255;
							if (e >= full_ms_m)
								w = 255 - (128 * (e - full_ms_m)) / (total_ms_m - full_ms_m);
							c.r = 8'(w);
							c.g = 8'(w);
							c.b = 8'(w);
						end
					end
					colours_due.push_back(c);
				end
			end
			default: ;
		endcase
	endfunction

	// driver: hold while stalled, otherwise predict the accepted request and offer the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid) begin
				predict_request(drv_req);
				case (drv_req.mode)
					kacl_pkg::MODE_RELEASE: n_release++;
					kacl_pkg::MODE_FRAME:   n_frame++;
					kacl_pkg::MODE_RENDER:  n_render++;
					default: ;
				endcase
			end
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				drv_req = req_backlog.pop_front();
				in_valid  <= 1'b1;
				mode      <= drv_req.mode;
				led_num   <= drv_req.led;
				layer     <= drv_req.layer;
				now_ms    <= drv_req.now;
				if ($urandom_range(0, 49) == 0)
					drv_burst = !drv_burst;
				gap_left = drv_burst ? 0 : $urandom_range(0, 5);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check each accepted colour against the oldest one due, and stall the output at random
	always @(posedge clk or negedge arst_n) begin
		led_rgb_t got, want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.led = led_out;
				got.r   = red;
				got.g   = green;
				got.b   = blue;
				if (colours_due.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("colour for led %0d arrived with none due", got.led);
				end else begin
					want = colours_due.pop_front();
					if (got.led !== want.led || got.r !== want.r || got.g !== want.g ||
					    got.b !== want.b) begin
						fail_cnt++;
						if (fail_cnt <= 10)
							$display("mismatch: expected led %0d rgb %0d %0d %0d, got led %0d rgb %0d %0d %0d",
							         want.led, want.r, want.g, want.b,
							         got.led, got.r, got.g, got.b);
					end
				end
				colours_seen <= colours_seen + 1;
				if ($urandom_range(0, 49) == 0)
					mon_burst = !mon_burst;
				stall_left = mon_burst ? 0 : $urandom_range(0, 5);
			end
			out_stall <= (hold_left != 0 || stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	// one long hold-off on the output so the block backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_used && colours_seen >= 100) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("nothing moved for %0d cycles, %0d colours still due", QUIET_LIMIT,
			         colours_due.size());
			$display("key_afterglow_led_colorizer verification failed");
			$finish;
		end
	end

	task automatic queue_req(logic [1:0] m, logic [7:0] led, logic [1:0] lyr, logic [31:0] t);
		led_req_t q;
		q.mode  = m;
		q.led   = led;
		q.layer = lyr;
		q.now   = t;
		req_backlog.push_back(q);
		if (m == kacl_pkg::MODE_FRAME ||
		    ((m == kacl_pkg::MODE_RELEASE || m == kacl_pkg::MODE_RENDER) &&
		     led < kacl_pkg::LED_COUNT_DEF))
			queued_live++;
	endtask

	task automatic write_reg(logic [kacl_pkg::CFG_IDX_W-1:0] idx,
	                         logic [kacl_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			kacl_pkg::REG_GLOW_TOTAL: total_ms_m = val;
			kacl_pkg::REG_GLOW_FULL:  full_ms_m  = val;
			kacl_pkg::REG_COLOR_STEP: step_ms_m  = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(int unsigned total, int unsigned full, int unsigned step);
		write_reg(kacl_pkg::REG_GLOW_TOTAL, kacl_pkg::CFG_W'(total));
		write_reg(kacl_pkg::REG_GLOW_FULL, kacl_pkg::CFG_W'(full));
		write_reg(kacl_pkg::REG_COLOR_STEP, kacl_pkg::CFG_W'(step));
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	// drain: every request taken, every colour in, then let a frame sweep finish
	task automatic settle();
		while (req_backlog.size() != 0 || in_valid)
			@(posedge clk);
		while (colours_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] on_board();
		return 8'($urandom_range(0, kacl_pkg::LED_COUNT_DEF - 1));
	endfunction

	function automatic logic [1:0] any_layer();
		return 2'($urandom_range(0, 3));
	endfunction

	task automatic random_phase(int n);
		int          target, pick, steps;
		int unsigned span;
		logic [7:0]  led;
		target = queued_live + n;
		span   = (total_ms_m > 16) ? total_ms_m / 4 : 4;
		while (queued_live < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				// release one key, then watch its glow through frames and renders
				led = on_board();
				queue_req(kacl_pkg::MODE_RELEASE, led, any_layer(), t_now);
				steps = $urandom_range(2, 6);
				repeat (steps) begin
					t_now += $urandom_range(0, span);
					case ($urandom_range(0, 3))
						0: queue_req(kacl_pkg::MODE_FRAME, 8'($urandom),
						             $urandom_range(0, 1) ? 2'd0 : any_layer(), t_now);
						1, 2: queue_req(kacl_pkg::MODE_RENDER, led, any_layer(), t_now);
						default: queue_req(kacl_pkg::MODE_RENDER, on_board(), any_layer(),
						                   t_now);
					endcase
				end
			end else if (pick < 90) begin
				t_now += $urandom_range(0, span);
				queue_req($urandom_range(0, 1) ? kacl_pkg::MODE_FRAME : kacl_pkg::MODE_RENDER,
				          on_board(), any_layer(), t_now);
			end else begin
				case ($urandom_range(0, 3))
					0: queue_req(MODE_UNUSED, 8'($urandom), any_layer(), $urandom);
					1: queue_req(kacl_pkg::MODE_RELEASE,
					             8'($urandom_range(kacl_pkg::LED_COUNT_DEF, 255)),
					             any_layer(), t_now);
					2: queue_req(kacl_pkg::MODE_RENDER,
					             8'($urandom_range(kacl_pkg::LED_COUNT_DEF, 255)),
					             any_layer(), t_now);
					default: begin
						t_now = $urandom;
						queue_req(kacl_pkg::MODE_FRAME, 8'($urandom), any_layer(), t_now);
					end
				endcase
			end
		end
	endtask

	initial begin
		int unsigned tot;
		foreach (glow_on[i]) begin
			glow_on[i] = 1'b0;
			glow_t0[i] = '0;
		end
		hue_seed_m  = 31'd1;
		hue_stamp_m = '0;
		total_ms_m  = kacl_pkg::GLOW_TOTAL_RST;
		full_ms_m   = kacl_pkg::GLOW_FULL_RST;
		step_ms_m   = kacl_pkg::COLOR_STEP_RST;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed requests at the reset settings
		queue_req(kacl_pkg::MODE_RENDER, 8'd0, 2'd0, 32'd0);
		queue_req(kacl_pkg::MODE_RENDER, 8'd46, 2'd0, 32'd0);
		queue_req(kacl_pkg::MODE_FRAME, 8'd0, 2'd0, 32'd100);      // step not yet exceeded
		queue_req(kacl_pkg::MODE_FRAME, 8'd0, 2'd0, 32'd101);      // advance the seed
		queue_req(kacl_pkg::MODE_RENDER, 8'd46, 2'd0, 32'd101);
		queue_req(kacl_pkg::MODE_RENDER, 8'd47, 2'd0, 32'd101);    // off the board
		queue_req(kacl_pkg::MODE_RENDER, 8'd255, 2'd3, 32'd101);
		queue_req(MODE_UNUSED, 8'd5, 2'd0, 32'd150);
		queue_req(kacl_pkg::MODE_RELEASE, 8'd255, 2'd0, 32'd200);
		queue_req(kacl_pkg::MODE_RELEASE, 8'd47, 2'd0, 32'd200);
		queue_req(kacl_pkg::MODE_RELEASE, 8'd0, 2'd1, 32'd1000);
		queue_req(kacl_pkg::MODE_RENDER, 8'd0, 2'd1, 32'd1000);
		queue_req(kacl_pkg::MODE_RENDER, 8'd0, 2'd1, 32'd1499);
		queue_req(kacl_pkg::MODE_RENDER, 8'd0, 2'd1, 32'd1500);
		queue_req(kacl_pkg::MODE_RENDER, 8'd0, 2'd1, 32'd1999);
		queue_req(kacl_pkg::MODE_RELEASE, 8'd0, 2'd1, 32'd1990);   // restart a live glow
		queue_req(kacl_pkg::MODE_RENDER, 8'd0, 2'd1, 32'd2400);
		queue_req(kacl_pkg::MODE_RELEASE, 8'd46, 2'd2, 32'd2400);
		queue_req(kacl_pkg::MODE_FRAME, 8'd0, 2'd2, 32'd3500);     // retire both glows only
		queue_req(kacl_pkg::MODE_RENDER, 8'd46, 2'd3, 32'd3500);
		queue_req(kacl_pkg::MODE_RENDER, 8'd0, 2'd2, 32'd3500);
		queue_req(kacl_pkg::MODE_RELEASE, 8'd11, 2'd2, 32'd3600);
		queue_req(kacl_pkg::MODE_RENDER, 8'd11, 2'd2, 32'd4600);   // glow expires at render
		queue_req(kacl_pkg::MODE_RENDER, 8'd11, 2'd2, 32'd4610);
		queue_req(kacl_pkg::MODE_RELEASE, 8'd5, 2'd0, 32'hffff_ff00);
		queue_req(kacl_pkg::MODE_RENDER, 8'd5, 2'd0, 32'h0000_0010); // time wraps
		queue_req(kacl_pkg::MODE_FRAME, 8'd255, 2'd0, 32'hffff_ffff);
		queue_req(kacl_pkg::MODE_RENDER, 8'd20, 2'd1, 32'hffff_ffff);
		queue_req(kacl_pkg::MODE_RENDER, 8'd12, 2'd1, 32'hffff_ffff);
		settle();

		t_now = $urandom;
		set_regs(65535, 0, 0);
		random_phase(150);
		settle();

		set_regs(1, 0, 65535);
		random_phase(150);
		settle();

		// full phase longer than the whole glow: white until it dies
		set_regs(300, 65534, 20);
		random_phase(150);
		settle();

		repeat (3) begin
			tot = $urandom_range(2, 4000);
			set_regs(tot, $urandom_range(0, tot - 1), $urandom_range(0, 300));
			random_phase(180);
			settle();
		end

		$display("%0d releases, %0d frame starts, %0d renders over %0d register settings",
		         n_release, n_frame, n_render, n_settings);
		$display("%0d colours checked, %0d failures", colours_seen, fail_cnt);
		if (fail_cnt == 0)
			$display("key_afterglow_led_colorizer verification clean");
		else
			$display("key_afterglow_led_colorizer verification failed");
		$finish;
	end

endmodule
